[rtl/rli_pkg.sv]
// shared types, constants and the divider step of the rounded linear interpolator
package rli_pkg;

  localparam int unsigned DataW      = 8;
  localparam int unsigned DivStages  = 4;
  localparam int unsigned BitsPerStg = DataW / DivStages;
  localparam int unsigned NumStg     = DivStages + 3;

  typedef logic [DataW-1:0] byte_t;

  typedef struct packed {
    logic  bypass;
    byte_t y_byp;
    byte_t y_low;
    logic  falling;
    byte_t span;
    byte_t dx;
    byte_t dy;
    byte_t rem;
    byte_t quo;
    byte_t dvd_lo;
  } pipe_t;

  // one restoring division step: returns {quotient bit, new remainder}
  function automatic logic [DataW:0] div_step(input byte_t rem, input logic dvd_bit,
                                              input byte_t span);
    logic [DataW:0] part;
    logic [DataW:0] diff;
    logic [DataW:0] res;
    part = {rem, dvd_bit};
    diff = part - {1'b0, span};
    if (part >= {1'b0, span}) begin
      res = {1'b1, diff[DataW-1:0]};
    end else begin
      res = {1'b0, part[DataW-1:0]};
    end
    return res;
  endfunction

endpackage

[rtl/rounded_linear_interpolator.sv]
// rounded linear interpolator between two 8-bit breakpoints, pipelined
//
//  channel  direction  handshake                  payload
//  in       input      in_valid_i / in_ready_o    x_low_i x_high_i y_at_low_i y_at_high_i query_x_i
//  out      output     out_valid_o / out_ready_i  y_out_o
//
// seven register stages: prepare, multiply, four divider stages of two bits, round and add
// one beat per cycle sustained without backpressure
// empty stages fill while the output stalls, so bubbles are squeezed out
// reset clears the valid bits only; a stall holds the occupied stages from the output back to the first empty stage
module rounded_linear_interpolator
  import rli_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  byte_t x_low_i,
  input  byte_t x_high_i,
  input  byte_t y_at_low_i,
  input  byte_t y_at_high_i,
  input  byte_t query_x_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output byte_t y_out_o
);

  pipe_t             pipe_q [NumStg];
  pipe_t             pipe_d [NumStg];
  logic [NumStg-1:0] vld_q;
  logic [NumStg-1:0] en;

  always_comb begin
    en[NumStg-1] = !vld_q[NumStg-1] || out_ready_i;
    for (int k = NumStg - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NumStg-1];
  assign y_out_o     = pipe_q[NumStg-1].y_byp;

  for (genvar k = 0; k < NumStg; k++) begin : g_stg
    if (k == 0) begin : g_prep
      always_comb begin
        pipe_d[k]         = '0;
        pipe_d[k].bypass  = (query_x_i <= x_low_i) || (query_x_i >= x_high_i);
        pipe_d[k].y_byp   = (query_x_i <= x_low_i) ? y_at_low_i : y_at_high_i;
        pipe_d[k].y_low   = y_at_low_i;
        pipe_d[k].falling = y_at_high_i < y_at_low_i;
        pipe_d[k].span    = x_high_i - x_low_i;
        pipe_d[k].dx      = query_x_i - x_low_i;
        pipe_d[k].dy      = (y_at_high_i < y_at_low_i) ? (y_at_low_i - y_at_high_i)
                                                       : (y_at_high_i - y_at_low_i);
      end
    end else if (k == 1) begin : g_mul
      logic [2*DataW-1:0] prod;
      assign prod = (2*DataW)'(pipe_q[k-1].dy) * (2*DataW)'(pipe_q[k-1].dx);
      always_comb begin
        pipe_d[k]        = pipe_q[k-1];
        pipe_d[k].rem    = prod[2*DataW-1:DataW];
        pipe_d[k].dvd_lo = prod[DataW-1:0];
        pipe_d[k].quo    = '0;
      end
    end else if (k < NumStg - 1) begin : g_div
      always_comb begin
        logic [DataW:0] step;
        pipe_d[k] = pipe_q[k-1];
        for (int j = 0; j < BitsPerStg; j++) begin
          step             = div_step(pipe_d[k].rem, pipe_d[k].dvd_lo[DataW-1], pipe_d[k].span);
          pipe_d[k].rem    = step[DataW-1:0];
          pipe_d[k].quo    = {pipe_d[k].quo[DataW-2:0], step[DataW]};
          pipe_d[k].dvd_lo = {pipe_d[k].dvd_lo[DataW-2:0], 1'b0};
        end
      end
    end else begin : g_fin
      byte_t q_rnd;
      assign q_rnd = pipe_q[k-1].quo
                   + byte_t'(pipe_q[k-1].rem >= (pipe_q[k-1].span >> 1));
      always_comb begin
        pipe_d[k] = pipe_q[k-1];
        if (!pipe_q[k-1].bypass) begin
          pipe_d[k].y_byp = pipe_q[k-1].falling ? (pipe_q[k-1].y_low - q_rnd)
                                                : (pipe_q[k-1].y_low + q_rnd);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en[k]) begin
        vld_q[k] <= (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k - 1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

endmodule

[rtl/rli_checker.sv]
// port checker for the rounded linear interpolator and its bind
module rli_checker
  import rli_pkg::*;
(
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_ready_o,
  input byte_t x_low_i,
  input byte_t x_high_i,
  input byte_t y_at_low_i,
  input byte_t y_at_high_i,
  input byte_t query_x_i,
  input logic  out_valid_o,
  input logic  out_ready_i,
  input byte_t y_out_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(y_out_o))
    else $error("stalled output beat changed");

  // a free output side never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input blocked while output side is free");

  // no result appears unless an input beat was offered or a result was valid within the pipeline depth
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$past(in_valid_i, 1) && !$past(in_valid_i, 2) && !$past(in_valid_i, 3) &&
     !$past(in_valid_i, 4) && !$past(in_valid_i, 5) && !$past(in_valid_i, 6) &&
     !$past(in_valid_i, 7) && !$past(out_valid_o, 1) && !$past(out_valid_o, 2) &&
     !$past(out_valid_o, 3) && !$past(out_valid_o, 4) && !$past(out_valid_o, 5) &&
     !$past(out_valid_o, 6) && !$past(out_valid_o, 7)) |-> !out_valid_o)
    else $error("result beat without an input beat");

endmodule

bind rounded_linear_interpolator rli_checker u_rli_checker (.*);

[dv/tb.sv]
// testbench for rounded_linear_interpolator: directed and random queries checked against a predictor
`timescale 1ns / 1ps

module tb;
  import rli_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned DrainCycles   = 20;
  localparam int unsigned PhaseItems    = 600;

  class interp_scoreboard;
    byte_t       expected_y[$];
    int unsigned queries;
    int unsigned results;
    int unsigned mismatches;

    function automatic byte_t predict_y(byte_t xl, byte_t xh, byte_t yl, byte_t yh,
                                        byte_t xq);
      byte_t       span;
      byte_t       dx;
      byte_t       dy;
      logic [15:0] prod;
      logic [15:0] quo;
      logic [15:0] rmd;
      logic        falling;
      if (xq <= xl) return yl;
      if (xq >= xh) return yh;
      span = xh - xl;
      if (span == '0) return yl;
      dx      = xq - xl;
      falling = yh < yl;
      dy      = falling ? yl - yh : yh - yl;
      prod    = 16'(dy) * 16'(dx);
      quo     = prod / 16'(span);
      rmd     = prod % 16'(span);
      if (rmd >= 16'(span >> 1)) quo = quo + 16'd1;
      return falling ? yl - quo[7:0] : yl + quo[7:0];
    endfunction

    function void note_query(byte_t xl, byte_t xh, byte_t yl, byte_t yh, byte_t xq);
      expected_y.push_back(predict_y(xl, xh, yl, yh, xq));
      queries++;
    endfunction

    function void check_y(byte_t actual);
      byte_t want;
      results++;
      if (expected_y.size() == 0) begin
        $display("%0t: unexpected y_out, expected none, actual %0d", $time, actual);
        mismatches++;
      end else begin
        want = expected_y.pop_front();
        if (actual !== want) begin
          $display("%0t: y_out mismatch, expected %0d, actual %0d", $time, want, actual);
          mismatches++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_y.size();
    endfunction
  endclass

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_ready_o;
  byte_t x_low_i;
  byte_t x_high_i;
  byte_t y_at_low_i;
  byte_t y_at_high_i;
  byte_t query_x_i;
  logic  out_valid_o;
  logic  out_ready_i;
  byte_t y_out_o;

  interp_scoreboard interp_sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_off_req  = 1'b0;
  int unsigned quiet_cycles  = 0;

  rounded_linear_interpolator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .x_low_i    (x_low_i),
    .x_high_i   (x_high_i),
    .y_at_low_i (y_at_low_i),
    .y_at_high_i(y_at_high_i),
    .query_x_i  (query_x_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .y_out_o    (y_out_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // beat monitor, result check and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        interp_sb.note_query(x_low_i, x_high_i, y_at_low_i, y_at_high_i, query_x_i);
      end
      if (out_valid_o && out_ready_i) begin
        interp_sb.check_y(y_out_o);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 interp_sb.pending());
        $display("FAIL rounded_linear_interpolator");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // result receiver with random stalls and one long hold-off
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_query(input byte_t xl, input byte_t xh, input byte_t yl,
                            input byte_t yh, input byte_t xq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    x_low_i     <= xl;
    x_high_i    <= xh;
    y_at_low_i  <= yl;
    y_at_high_i <= yh;
    query_x_i   <= xq;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // mostly ordered breakpoints with the query inside, the rest edge cases and noise
  task automatic send_random_query();
    byte_t       a;
    byte_t       b;
    byte_t       xl;
    byte_t       xh;
    byte_t       yl;
    byte_t       yh;
    byte_t       xq;
    int unsigned pick;
    pick = $urandom_range(99);
    a    = byte_t'($urandom);
    b    = byte_t'($urandom);
    yl   = byte_t'($urandom);
    yh   = byte_t'($urandom);
    xq   = byte_t'($urandom);
    if (pick < 15) begin
      xl = byte_t'($urandom_range(250));
      xh = xl + byte_t'($urandom_range(5, 2));
      xq = byte_t'($urandom_range(xh, xl));
    end else if (pick < 70) begin
      xl = (a < b) ? a : b;
      xh = (a < b) ? b : a;
      xq = byte_t'($urandom_range(xh, xl));
    end else if (pick < 80) begin
      xl = a;
      xh = a;
    end else begin
      xl = a;
      xh = b;
    end
    if ($urandom_range(9) == 0) yh = yl;
    send_query(xl, xh, yl, yh, xq);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    x_low_i     = '0;
    x_high_i    = '0;
    y_at_low_i  = '0;
    y_at_high_i = '0;
    query_x_i   = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 13;
    recv_idle_pct = 56;
    send_query(8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
    send_query(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_query(8'd0,   8'd255, 8'd0,   8'd255, 8'd128);
    send_query(8'd0,   8'd255, 8'd255, 8'd0,   8'd128);
    send_query(8'd0,   8'd255, 8'd255, 8'd0,   8'd254);
    send_query(8'd0,   8'd255, 8'd0,   8'd255, 8'd1);
    send_query(8'd1,   8'd255, 8'd255, 8'd0,   8'd254);
    send_query(8'd0,   8'd255, 8'd255, 8'd255, 8'd100);
    send_query(8'd10,  8'd20,  8'd5,   8'd50,  8'd10);
    send_query(8'd10,  8'd20,  8'd5,   8'd50,  8'd3);
    send_query(8'd10,  8'd20,  8'd5,   8'd50,  8'd20);
    send_query(8'd10,  8'd20,  8'd5,   8'd50,  8'd255);
    send_query(8'd200, 8'd50,  8'd7,   8'd9,   8'd100);
    send_query(8'd200, 8'd50,  8'd7,   8'd9,   8'd200);
    send_query(8'd200, 8'd50,  8'd7,   8'd9,   8'd250);
    send_query(8'd77,  8'd77,  8'd1,   8'd2,   8'd77);
    send_query(8'd77,  8'd77,  8'd1,   8'd2,   8'd78);
    send_query(8'd77,  8'd77,  8'd1,   8'd2,   8'd10);
    send_query(8'd0,   8'd2,   8'd0,   8'd1,   8'd1);
    send_query(8'd0,   8'd2,   8'd255, 8'd0,   8'd1);
    send_query(8'd0,   8'd3,   8'd0,   8'd1,   8'd2);
    send_query(8'd0,   8'd4,   8'd0,   8'd1,   8'd1);
    send_query(8'd0,   8'd4,   8'd0,   8'd1,   8'd2);

    repeat (PhaseItems) send_random_query();

    send_idle_pct = 56;
    recv_idle_pct = 13;
    repeat (PhaseItems) send_random_query();

    // receiver holds off while the sender keeps the input full
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req  = 1'b1;
    repeat (PhaseItems) send_random_query();
    in_valid_i <= 1'b0;

    while (interp_sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("ran %0d queries (directed edge cases, then three idle mixes and a long hold-off)",
             interp_sb.queries);
    $display("checked %0d results, %0d mismatches", interp_sb.results, interp_sb.mismatches);
    if (interp_sb.mismatches == 0 && interp_sb.pending() == 0) begin
      $display("PASS rounded_linear_interpolator");
    end else begin
      $display("FAIL rounded_linear_interpolator");
    end
    $finish;
  end

endmodule
